FILE: rtl/core/cqtm_pkg.sv
// Shared types, codes and helpers for the CIGAR query-to-target mapper.
// Used by cqtm_step and cigar_query_to_target_mapper_unit; no dependencies.
`default_nettype none

package cqtm_pkg;

    localparam int POS_WIDTH = 32;              // signed position arithmetic width
    localparam int FIELD_W   = POS_WIDTH - 1;   // unsigned position field width
    localparam int WW        = POS_WIDTH + 4;   // headroom for sums and x10

    localparam logic signed [WW-1:0] POS_MAX = (WW'(1) <<< FIELD_W) - WW'(1);

    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_CHAR   = 1'b1;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_I  = 8'h49;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_P  = 8'h50;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_INSERTION     = 3'd1,
        ST_NO_MAPPING    = 3'd2,
        ST_MISSING_CIGAR = 3'd3,
        ST_OUT_OF_RANGE  = 3'd4,
        ST_BAD_CIGAR     = 3'd5
    } status_t;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] query_pos;
        logic [FIELD_W-1:0] query_start;
        logic [FIELD_W-1:0] query_end;
        logic [FIELD_W-1:0] query_length;
        logic [FIELD_W-1:0] target_start;
        logic               reverse_strand;
        logic               cigar_present;
        logic [7:0]         cigar_char;
        logic               last_char;
    } item_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] oriented_query;
        logic signed [POS_WIDTH-1:0] query_cursor;
        logic [FIELD_W-1:0]          target_cursor;
        logic [FIELD_W-1:0]          query_used;
        logic [FIELD_W-1:0]          target_used;
        logic [FIELD_W-1:0]          length_accum;
        logic                        have_digits;
        logic                        record_open;
    } state_t;

    typedef struct packed {
        status_t                     status;
        logic [FIELD_W-1:0]          target_pos;
        logic [7:0]                  op_char;
        logic [FIELD_W-1:0]          op_length;
        logic [FIELD_W-1:0]          op_offset;
        logic signed [POS_WIDTH-1:0] oriented_pos;
        logic [FIELD_W-1:0]          query_consumed;
        logic [FIELD_W-1:0]          target_consumed;
    } result_t;

    function automatic logic signed [WW-1:0] ext_u(input logic [FIELD_W-1:0] v);
        return $signed({{(WW-FIELD_W){1'b0}}, v});
    endfunction

    function automatic logic signed [WW-1:0] ext_s(input logic signed [POS_WIDTH-1:0] v);
        return $signed({{(WW-POS_WIDTH){v[POS_WIDTH-1]}}, v});
    endfunction

    // Clamp to [0, POS_MAX] and narrow to a field.
    function automatic logic [FIELD_W-1:0] clamp_pos(input logic signed [WW-1:0] v);
        logic [FIELD_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > POS_MAX) begin
            r = POS_MAX[FIELD_W-1:0];
        end else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    // Saturate at POS_MAX only; negative cursors pass through.
    function automatic logic signed [POS_WIDTH-1:0] sat_cursor(input logic signed [WW-1:0] v);
        logic signed [POS_WIDTH-1:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX[POS_WIDTH-1:0];
        end else begin
            r = v[POS_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cqtm_step.sv
// Per-word decision logic: next record state and the optional result word.
// Depends on cqtm_pkg.
`default_nettype none

module cqtm_step (
    input  cqtm_pkg::item_t   item,
    input  cqtm_pkg::state_t  st,
    output cqtm_pkg::state_t  st_next,
    output logic              emit,
    output cqtm_pkg::result_t res
);
    import cqtm_pkg::*;

    logic signed [WW-1:0] ori_w;
    logic signed [WW-1:0] cur_w;
    logic signed [WW-1:0] len_w;
    logic signed [WW-1:0] tc_w;
    logic signed [WW-1:0] off_w;
    logic signed [WW-1:0] acc_w;
    logic signed [WW-1:0] qpos_w;
    logic signed [WW-1:0] mirror_ori_w;
    logic signed [WW-1:0] mirror_cur_w;
    logic [7:0]           digit;
    logic                 is_digit;
    logic                 hit;

    always_comb begin
        ori_w        = ext_s(st.oriented_query);
        cur_w        = ext_s(st.query_cursor);
        len_w        = ext_u(st.length_accum);
        tc_w         = ext_u(st.target_cursor);
        off_w        = ori_w - cur_w;
        hit          = ori_w < (cur_w + len_w);
        digit        = item.cigar_char - CH_0;
        is_digit     = item.cigar_char inside {[CH_0:CH_9]};
        acc_w        = (len_w <<< 3) + (len_w <<< 1) + $signed({{(WW-8){1'b0}}, digit});
        qpos_w       = ext_u(item.query_pos);
        mirror_ori_w = ext_u(item.query_length) - WW'(1) - qpos_w;
        mirror_cur_w = ext_u(item.query_length) - ext_u(item.query_end);

        st_next = st;
        emit    = 1'b0;
        res     = '0;

        if (item.func == FUNC_HEADER) begin
            st_next.record_open  = 1'b0;
            st_next.have_digits  = 1'b0;
            st_next.length_accum = '0;
            st_next.query_used   = '0;
            st_next.target_used  = '0;
            if (!item.cigar_present) begin
                emit             = 1'b1;
                res.status       = ST_MISSING_CIGAR;
                res.oriented_pos = '1;
            end else if (item.query_pos < item.query_start ||
                         item.query_pos >= item.query_end) begin
                emit             = 1'b1;
                res.status       = ST_OUT_OF_RANGE;
                res.oriented_pos = '1;
            end else begin
                if (item.reverse_strand) begin
                    st_next.oriented_query = mirror_ori_w[POS_WIDTH-1:0];
                    st_next.query_cursor   = mirror_cur_w[POS_WIDTH-1:0];
                end else begin
                    st_next.oriented_query = qpos_w[POS_WIDTH-1:0];
                    st_next.query_cursor   = $signed({1'b0, item.query_start});
                end
                st_next.target_cursor = item.target_start;
                st_next.record_open   = 1'b1;
            end
        end else if (st.record_open) begin
            if (is_digit) begin
                st_next.length_accum = clamp_pos(acc_w);
                st_next.have_digits  = 1'b1;
            end else if (st.have_digits) begin
                st_next.length_accum = '0;
                st_next.have_digits  = 1'b0;
                res.op_char          = item.cigar_char;
                res.op_length        = st.length_accum;
                res.oriented_pos     = st.oriented_query;
                res.query_consumed   = st.query_used;
                res.target_consumed  = st.target_used;
                case (item.cigar_char)
                    CH_M, CH_EQ, CH_X: begin
                        if (hit) begin
                            emit           = 1'b1;
                            res.status     = ST_OK;
                            res.target_pos = clamp_pos(tc_w + off_w);
                            res.op_offset  = clamp_pos(off_w);
                        end else begin
                            st_next.query_cursor  = sat_cursor(cur_w + len_w);
                            st_next.target_cursor = clamp_pos(tc_w + len_w);
                            st_next.query_used    = clamp_pos(ext_u(st.query_used) + len_w);
                            st_next.target_used   = clamp_pos(ext_u(st.target_used) + len_w);
                        end
                    end
                    CH_I, CH_S: begin
                        if (hit) begin
                            emit          = 1'b1;
                            res.status    = ST_INSERTION;
                            res.op_offset = clamp_pos(off_w);
                        end else begin
                            st_next.query_cursor = sat_cursor(cur_w + len_w);
                            st_next.query_used   = clamp_pos(ext_u(st.query_used) + len_w);
                        end
                    end
                    CH_D, CH_N: begin
                        st_next.target_cursor = clamp_pos(tc_w + len_w);
                        st_next.target_used   = clamp_pos(ext_u(st.target_used) + len_w);
                    end
                    CH_H, CH_P: begin
                    end
                    default: begin
                        emit       = 1'b1;
                        res.status = ST_BAD_CIGAR;
                    end
                endcase
                if (emit) begin
                    st_next.record_open = 1'b0;
                end
            end
            // close an undecided record on its final character
            if (item.last_char && !emit) begin
                st_next.record_open  = 1'b0;
                st_next.length_accum = '0;
                st_next.have_digits  = 1'b0;
                emit                 = 1'b1;
                res                  = '0;
                res.status           = ST_NO_MAPPING;
                res.oriented_pos     = st.oriented_query;
                res.query_consumed   = st_next.query_used;
                res.target_consumed  = st_next.target_used;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cigar_query_to_target_mapper_unit.sv
// Top level of the CIGAR query-to-target mapper: input register, record
// state, result register. Depends on cqtm_pkg and cqtm_step.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   s_       | s_valid / s_ready  | header word or one CIGAR character word
//   m_       | m_valid / m_ready  | one mapping result word per record
//
// One word per cycle; an emitting word waits while the result is stalled, and
// m_valid is registered with the result. The step logic between the input and
// result registers computes the next record state, so each word updates it
// as it leaves the input register. aresetn clears valid flags and record state.
// A stalled result holds only words that would emit; other words pass.
`default_nettype none

module cigar_query_to_target_mapper_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_func,
    input  wire logic [cqtm_pkg::FIELD_W-1:0]       s_query_pos,
    input  wire logic [cqtm_pkg::FIELD_W-1:0]       s_query_start,
    input  wire logic [cqtm_pkg::FIELD_W-1:0]       s_query_end,
    input  wire logic [cqtm_pkg::FIELD_W-1:0]       s_query_length,
    input  wire logic [cqtm_pkg::FIELD_W-1:0]       s_target_start,
    input  wire logic                               s_reverse_strand,
    input  wire logic                               s_cigar_present,
    input  wire logic [7:0]                         s_cigar_char,
    input  wire logic                               s_last_char,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [2:0]                              m_status,
    output logic [cqtm_pkg::FIELD_W-1:0]            m_target_pos,
    output logic [7:0]                              m_op_char,
    output logic [cqtm_pkg::FIELD_W-1:0]            m_op_length,
    output logic [cqtm_pkg::FIELD_W-1:0]            m_op_offset,
    output logic signed [cqtm_pkg::POS_WIDTH-1:0]   m_oriented_pos,
    output logic [cqtm_pkg::FIELD_W-1:0]            m_query_consumed,
    output logic [cqtm_pkg::FIELD_W-1:0]            m_target_consumed
);
    import cqtm_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res_reg;
    result_t step_res;
    logic    out_valid_reg;
    logic    step_emit;
    logic    out_ready;
    logic    advance;
    logic    s_accept;

    cqtm_step u_step (
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .emit    (step_emit),
        .res     (step_res)
    );

    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && (!step_emit || out_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                st_reg <= st_next;
            end
            if (advance && step_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.func           <= s_func;
            item_reg.query_pos      <= s_query_pos;
            item_reg.query_start    <= s_query_start;
            item_reg.query_end      <= s_query_end;
            item_reg.query_length   <= s_query_length;
            item_reg.target_start   <= s_target_start;
            item_reg.reverse_strand <= s_reverse_strand;
            item_reg.cigar_present  <= s_cigar_present;
            item_reg.cigar_char     <= s_cigar_char;
            item_reg.last_char      <= s_last_char;
        end
        if (advance && step_emit) begin
            res_reg <= step_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = res_reg.status;
    assign m_target_pos      = res_reg.target_pos;
    assign m_op_char         = res_reg.op_char;
    assign m_op_length       = res_reg.op_length;
    assign m_op_offset       = res_reg.op_offset;
    assign m_oriented_pos    = res_reg.oriented_pos;
    assign m_query_consumed  = res_reg.query_consumed;
    assign m_target_consumed = res_reg.target_consumed;

    a_rise_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance && step_emit))
        else $error("result word appeared without an emitting step");

    a_header_missing_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.func == FUNC_HEADER && !item_reg.cigar_present
        |=> !st_reg.record_open)
        else $error("record left open after header without CIGAR");

    a_closed_char_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && item_reg.func == FUNC_CHAR && !st_reg.record_open |-> !step_emit)
        else $error("character word outside a record produced a result");

    a_ok_op_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK
        |-> (m_op_char == CH_M || m_op_char == CH_EQ || m_op_char == CH_X))
        else $error("ok result decided by a non-match op");

endmodule

`default_nettype wire
